>>> rtl/sacl_pkg.sv
// Shared constants, types and helper functions for the LRU cache tag tracker.
package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  localparam int KIND_W      = 2;
  localparam int OUTCOME_W   = 2;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SET_CFG_W   = 4;
  localparam int WAYS_CFG_W  = 4;
  localparam int OFF_CFG_W   = 6;
  localparam int OFFSET_MAX  = 32;
  localparam int SHIFT_W     = 6;

  localparam int OUT_FIELDS_W = OUTCOME_W + 1 + 3 * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_EXTRA_LSB = OUTCOME_W;
  localparam int OUT_HIT_LSB   = OUTCOME_W + 1;
  localparam int OUT_MISS_LSB  = OUT_HIT_LSB + CNT_W;
  localparam int OUT_EVICT_LSB = OUT_MISS_LSB + CNT_W;

  localparam logic [SET_CFG_W-1:0]  SET_BITS_RST    = 4'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST        = 4'd1;
  localparam logic [OFF_CFG_W-1:0]  OFFSET_BITS_RST = 6'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD,
    KIND_STORE,
    KIND_MODIFY,
    KIND_IFETCH
  } kind_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT,
    OUT_FILL,
    OUT_EVICT
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS,
    REG_WAYS,
    REG_OFFSET_BITS
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    outcome_t outcome;
    logic     is_hit;
    logic     is_miss;
    logic     is_evict;
  } lookup_res_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/sacl_row_ram.sv
// Set row memory with registered read and per-row written flags.
module sacl_row_ram #(
  parameter int SET_W = 8,
  parameter int ROW_W = 528
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [SET_W-1:0] rd_addr,
  output logic [ROW_W-1:0] rd_data,
  output logic             rd_fresh,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  localparam int NUM_SETS = 1 << SET_W;

  logic [ROW_W-1:0]    mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // A row that was never written reads as all lines invalid with rank zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      rd_fresh    <= 1'b1;
    end else begin
      if (wr_en) begin
        row_written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_fresh <= ~row_written[rd_addr];
      end
    end
  end

endmodule

>>> rtl/sacl_lookup.sv
// Tag compare, victim choice and LRU rank update for one set row.
module sacl_lookup
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 62,
  parameter int RANK_W   = 3,
  parameter int WC_W     = 4,
  parameter int ROW_W    = 528
) (
  input  logic [ROW_W-1:0] row_in,
  input  logic             row_fresh,
  input  logic [TAG_W-1:0] tag,
  input  logic [WC_W-1:0]  ways,
  output logic [ROW_W-1:0] row_out,
  output lookup_res_t      res
);

  localparam int RANK_LSB = MAX_WAYS;
  localparam int TAG_LSB  = MAX_WAYS + MAX_WAYS * RANK_W;

  logic [MAX_WAYS-1:0] act;
  logic [MAX_WAYS-1:0] vld;
  logic [MAX_WAYS-1:0] hitv;
  logic [MAX_WAYS-1:0] freev;
  logic [RANK_W-1:0]   rk [MAX_WAYS];
  logic [TAG_W-1:0]    tg [MAX_WAYS];

  logic              found;
  logic              free_found;
  logic [RANK_W-1:0] hway;
  logic [RANK_W-1:0] fway;
  logic [RANK_W-1:0] vway;
  logic [RANK_W-1:0] best;
  logic [RANK_W-1:0] way;
  logic [WC_W-1:0]   limit;

  for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
    assign act[w]   = WC_W'(w) < ways;
    assign vld[w]   = ~row_fresh & row_in[w];
    assign rk[w]    = row_fresh ? '0 : row_in[RANK_LSB + w * RANK_W +: RANK_W];
    assign tg[w]    = row_in[TAG_LSB + w * TAG_W +: TAG_W];
    assign hitv[w]  = act[w] & vld[w] & (tg[w] == tag);
    assign freev[w] = act[w] & ~vld[w];
  end

  always_comb begin
    found      = |hitv;
    free_found = |freev;
    hway       = '0;
    fway       = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hway = RANK_W'(w);
      end
      if (freev[w]) begin
        fway = RANK_W'(w);
      end
    end
    // Ties on rank keep the lowest way.
    vway = '0;
    best = rk[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (act[w] && (rk[w] > best)) begin
        best = rk[w];
        vway = RANK_W'(w);
      end
    end
    if (found) begin
      way   = hway;
      limit = WC_W'(rk[hway]);
    end else if (free_found) begin
      way   = fway;
      limit = WC_W'(MAX_WAYS);
    end else begin
      way   = vway;
      limit = WC_W'(best);
    end
  end

  always_comb begin
    row_out = row_in;
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_out[w] = vld[w];
      row_out[RANK_LSB + w * RANK_W +: RANK_W] = rk[w];
      if (act[w] && vld[w] && (WC_W'(rk[w]) < limit) && (int'(rk[w]) < MAX_WAYS - 1)) begin
        row_out[RANK_LSB + w * RANK_W +: RANK_W] = rk[w] + 1'b1;
      end
      if (RANK_W'(w) == way) begin
        row_out[RANK_LSB + w * RANK_W +: RANK_W] = '0;
        if (!found) begin
          row_out[w] = 1'b1;
          row_out[TAG_LSB + w * TAG_W +: TAG_W] = tag;
        end
      end
    end
  end

  always_comb begin
    res.is_hit   = found;
    res.is_miss  = ~found;
    res.is_evict = ~found & ~free_found;
    if (found) begin
      res.outcome = OUT_HIT;
    end else if (free_found) begin
      res.outcome = OUT_FILL;
    end else begin
      res.outcome = OUT_EVICT;
    end
  end

endmodule

>>> rtl/set_assoc_cache_lru_tracker.sv
// Top level of the set-associative cache tag tracker with LRU replacement.
// Each data request (load, store, modify) reads its set row from a one-port-read,
// one-port-write memory in the cycle it is taken. In the lookup state, once the
// output register is free, the row is compared, updated and written back while the
// result enters the output register; an instruction fetch gives no result. Only
// one request is in flight, so a read never meets a pending write to the same row.
// A per-row written flag cleared by reset makes fresh rows read as empty; no
// clearing pass is needed after reset. Configuration is taken through cfg_we,
// cfg_index and cfg_data and must only change while idle.
module set_assoc_cache_lru_tracker
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  localparam int IN_DATA_W   = ((ADDR_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // address
  input  logic [KIND_W-1:0]     s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // outcome, extra_hit, hit_total,
                                           // miss_total, eviction_total
);

  localparam int SET_W  = MAX_SET_BITS;
  localparam int TAG_W  = ADDR_WIDTH - 2;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W   = $clog2(MAX_WAYS + 1);
  localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
  localparam int ROW_W  = MAX_WAYS * (1 + RANK_W + TAG_W);

  state_t state;
  state_t state_next;

  logic [SET_CFG_W-1:0]  set_bits_cfg;
  logic [WAYS_CFG_W-1:0] ways_cfg;
  logic [OFF_CFG_W-1:0]  offset_cfg;

  logic [SB_W-1:0]      set_bits_cl;
  logic [WC_W-1:0]      ways_cl;
  logic [OFF_CFG_W-1:0] offset_cl;
  logic [SHIFT_W-1:0]   shift;

  logic [ADDR_WIDTH-1:0] addr;
  logic [TAG_W-1:0]      addr_tag;
  logic [SET_W-1:0]      set_raw;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_idx;

  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;
  logic             modify_q;

  logic accept;
  logic start;
  logic commit;

  logic [ROW_W-1:0] rd_row;
  logic             rd_fresh;
  logic [ROW_W-1:0] wr_row;
  lookup_res_t      res;

  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;
  logic [CNT_W-1:0] hit_cnt_next;
  logic [CNT_W-1:0] miss_cnt_next;
  logic [CNT_W-1:0] evict_cnt_next;
  logic [OUT_DATA_W-1:0] out_data;

  always_comb begin
    if (set_bits_cfg == '0) begin
      set_bits_cl = SB_W'(1);
    end else if (int'(set_bits_cfg) > MAX_SET_BITS) begin
      set_bits_cl = SB_W'(MAX_SET_BITS);
    end else begin
      set_bits_cl = SB_W'(set_bits_cfg);
    end
    if (ways_cfg == '0) begin
      ways_cl = WC_W'(1);
    end else if (int'(ways_cfg) > MAX_WAYS) begin
      ways_cl = WC_W'(MAX_WAYS);
    end else begin
      ways_cl = WC_W'(ways_cfg);
    end
    if (offset_cfg == '0) begin
      offset_cl = OFF_CFG_W'(1);
    end else if (int'(offset_cfg) > OFFSET_MAX) begin
      offset_cl = OFF_CFG_W'(OFFSET_MAX);
    end else begin
      offset_cl = offset_cfg;
    end
  end

  assign shift    = SHIFT_W'(set_bits_cl) + SHIFT_W'(offset_cl);
  assign addr     = s_tdata[ADDR_WIDTH-1:0];
  assign addr_tag = TAG_W'(addr >> shift);
  assign set_raw  = SET_W'(addr >> offset_cl);

  for (genvar i = 0; i < SET_W; i++) begin : g_set_mask
    assign set_mask[i] = SB_W'(i) < set_bits_cl;
  end
  assign set_idx = set_raw & set_mask;

  assign accept = s_tvalid & s_tready;
  assign start  = accept & (kind_t'(s_tuser) != KIND_IFETCH);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_LOOKUP: begin
        commit = ~m_tvalid | m_tready;
      end
      default: begin
        s_tready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  sacl_row_ram #(
    .SET_W(SET_W),
    .ROW_W(ROW_W)
  ) u_row_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (start),
    .rd_addr (set_idx),
    .rd_data (rd_row),
    .rd_fresh(rd_fresh),
    .wr_en   (commit),
    .wr_addr (set_q),
    .wr_data (wr_row)
  );

  sacl_lookup #(
    .MAX_WAYS(MAX_WAYS),
    .TAG_W   (TAG_W),
    .RANK_W  (RANK_W),
    .WC_W    (WC_W),
    .ROW_W   (ROW_W)
  ) u_lookup (
    .row_in   (rd_row),
    .row_fresh(rd_fresh),
    .tag      (tag_q),
    .ways     (ways_cl),
    .row_out  (wr_row),
    .res      (res)
  );

  assign hit_cnt_next   = sat_add(hit_cnt, 2'(res.is_hit) + 2'(modify_q));
  assign miss_cnt_next  = sat_add(miss_cnt, 2'(res.is_miss));
  assign evict_cnt_next = sat_add(evict_cnt, 2'(res.is_evict));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      set_bits_cfg <= SET_BITS_RST;
      ways_cfg     <= WAYS_RST;
      offset_cfg   <= OFFSET_BITS_RST;
      hit_cnt      <= '0;
      miss_cnt     <= '0;
      evict_cnt    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SET_BITS:    set_bits_cfg <= cfg_data[SET_CFG_W-1:0];
          REG_WAYS:        ways_cfg     <= cfg_data[WAYS_CFG_W-1:0];
          REG_OFFSET_BITS: offset_cfg   <= cfg_data[OFF_CFG_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        hit_cnt   <= hit_cnt_next;
        miss_cnt  <= miss_cnt_next;
        evict_cnt <= evict_cnt_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tag_q    <= addr_tag;
      set_q    <= set_idx;
      modify_q <= kind_t'(s_tuser) == KIND_MODIFY;
    end
    if (commit) begin
      out_data <= OUT_DATA_W'({evict_cnt_next, miss_cnt_next, hit_cnt_next,
                               modify_q, res.outcome});
    end
  end

  assign m_tdata = out_data;

endmodule

>>> rtl/sacl_checker.sv
// Port-level checks of the cache tracker, bound to its top level.
module sacl_checker
  import sacl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [KIND_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != KIND_IFETCH) |=> !s_tready)
    else $error("Data request taken while another is in flight.");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUTCOME_W-1:0] == OUT_HIT) ||
                 (m_tdata[OUTCOME_W-1:0] == OUT_FILL) ||
                 (m_tdata[OUTCOME_W-1:0] == OUT_EVICT))
    else $error("Undefined outcome code.");

  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUTCOME_W-1:0] != OUT_HIT) |->
      (m_tdata[OUT_MISS_LSB +: CNT_W] != '0))
    else $error("Miss reported with zero miss total.");

  a_evict_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUTCOME_W-1:0] == OUT_EVICT) |->
      (m_tdata[OUT_EVICT_LSB +: CNT_W] != '0))
    else $error("Eviction reported with zero eviction total.");

endmodule

bind set_assoc_cache_lru_tracker sacl_checker u_sacl_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the set-associative cache tag tracker with LRU replacement.
module testbench;
  import sacl_pkg::*;

  localparam int NUM_LINES  = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    kind_t       kind;
    logic [63:0] addr;
  } access_t;

  typedef struct {
    outcome_t    outcome;
    logic        extra_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } access_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = KIND_LOAD;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow copy of the tag store and its settings.
  logic [3:0]  set_bits_reg;
  logic [3:0]  ways_reg;
  logic [5:0]  offset_reg;
  bit          line_valid [NUM_LINES];
  logic [61:0] line_tag [NUM_LINES];
  logic [2:0]  line_rank [NUM_LINES];
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] evict_count;

  access_t        access_queue[$];
  access_result_t expected_outcomes[$];
  access_t        current_access;
  access_result_t want;
  int             send_gap = 0;
  int             stall_left = 0;
  int             hold_left = 0;
  int             hold_seq = 0;
  int             hold_seen = 0;
  int             idle_cycles = 0;
  int             mismatches = 0;
  bit             quiet = 1'b0;

  set_assoc_cache_lru_tracker i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic age_lines(int unsigned base, int unsigned ways, int unsigned limit);
    int unsigned w;
    int unsigned i;
    for (w = 0; w < ways; w++) begin
      i = base + w;
      if (line_valid[i] && line_rank[i] < limit && line_rank[i] < MAX_WAYS_DEF - 1)
        line_rank[i] = line_rank[i] + 3'd1;
    end
  endtask

  task automatic cache_access(kind_t kind, logic [63:0] addr);
    int unsigned s, e, b, set_idx, base, way, best, w;
    logic [61:0] tag;
    bit found, free_way;
    access_result_t r;
    if (kind == KIND_IFETCH) return;
    s = clamp_range(set_bits_reg, 1, MAX_SET_BITS_DEF);
    e = clamp_range(ways_reg, 1, MAX_WAYS_DEF);
    b = clamp_range(offset_reg, 1, OFFSET_MAX);
    tag = 62'(addr >> (s + b));
    set_idx = int'((addr >> b) & ((64'd1 << s) - 64'd1));
    base = set_idx * MAX_WAYS_DEF;
    found = 1'b0;
    free_way = 1'b0;
    way = 0;
    for (w = 0; w < e && !found; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) begin
        way = w;
        found = 1'b1;
      end
    end
    if (found) begin
      age_lines(base, e, line_rank[base + way]);
      line_rank[base + way] = 3'd0;
      hit_count = bump(hit_count);
      r.outcome = OUT_HIT;
    end else begin
      miss_count = bump(miss_count);
      for (w = 0; w < e && !free_way; w++) begin
        if (!line_valid[base + w]) begin
          way = w;
          free_way = 1'b1;
        end
      end
      if (free_way) begin
        age_lines(base, e, MAX_WAYS_DEF);
        r.outcome = OUT_FILL;
      end else begin
        way = 0;
        best = line_rank[base];
        for (w = 1; w < e; w++) begin
          if (line_rank[base + w] > best) begin
            best = line_rank[base + w];
            way = w;
          end
        end
        age_lines(base, e, best);
        evict_count = bump(evict_count);
        r.outcome = OUT_EVICT;
      end
      line_valid[base + way] = 1'b1;
      line_tag[base + way] = tag;
      line_rank[base + way] = 3'd0;
    end
    if (kind == KIND_MODIFY) hit_count = bump(hit_count);
    r.extra_hit = (kind == KIND_MODIFY);
    r.hits = hit_count;
    r.misses = miss_count;
    r.evictions = evict_count;
    expected_outcomes.push_back(r);
  endtask

  // Request driver: accepted requests go through the shadow model.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) cache_access(current_access.kind, current_access.addr);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (access_queue.size() > 0) begin
          current_access = access_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= current_access.addr;
          s_tuser <= current_access.kind;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no pending request: m_tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        if (m_tdata[OUTCOME_W-1:0] !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, m_tdata[OUTCOME_W-1:0]);
          mismatches++;
        end
        if (m_tdata[OUT_EXTRA_LSB] !== want.extra_hit) begin
          $error("extra_hit: expected %0d, actual %0d", want.extra_hit,
                 m_tdata[OUT_EXTRA_LSB]);
          mismatches++;
        end
        if (m_tdata[OUT_HIT_LSB +: CNT_W] !== want.hits) begin
          $error("hit_total: expected %0d, actual %0d", want.hits,
                 m_tdata[OUT_HIT_LSB +: CNT_W]);
          mismatches++;
        end
        if (m_tdata[OUT_MISS_LSB +: CNT_W] !== want.misses) begin
          $error("miss_total: expected %0d, actual %0d", want.misses,
                 m_tdata[OUT_MISS_LSB +: CNT_W]);
          mismatches++;
        end
        if (m_tdata[OUT_EVICT_LSB +: CNT_W] !== want.evictions) begin
          $error("eviction_total: expected %0d, actual %0d", want.evictions,
                 m_tdata[OUT_EVICT_LSB +: CNT_W]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_access(kind_t kind, logic [63:0] addr);
    access_t a;
    a.kind = kind;
    a.addr = addr;
    access_queue.push_back(a);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (access_queue.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(logic [5:0] set_val, logic [5:0] ways_val, logic [5:0] off_val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SET_BITS;
    cfg_data <= set_val;
    set_bits_reg = set_val[3:0];
    @(posedge clk);
    cfg_index <= REG_WAYS;
    cfg_data <= ways_val;
    ways_reg = ways_val[3:0];
    @(posedge clk);
    cfg_index <= REG_OFFSET_BITS;
    cfg_data <= off_val;
    offset_reg = off_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Most requests reuse a few tags and sets so that hits, fills and evictions all occur.
  task automatic queue_random_accesses(int n);
    int unsigned s, e, b, data_items, i;
    logic [63:0] tag_pool [10];
    logic [63:0] set_pool [3];
    logic [63:0] addr;
    kind_t kind;
    s = clamp_range(set_bits_reg, 1, MAX_SET_BITS_DEF);
    e = clamp_range(ways_reg, 1, MAX_WAYS_DEF);
    b = clamp_range(offset_reg, 1, OFFSET_MAX);
    for (i = 0; i < 10; i++) tag_pool[i] = {$urandom, $urandom};
    for (i = 0; i < 3; i++) set_pool[i] = 64'($urandom_range(0, (1 << s) - 1));
    data_items = 0;
    while (data_items < n) begin
      kind = kind_t'($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0)
        addr = {$urandom, $urandom};
      else
        addr = (tag_pool[$urandom_range(0, e + 1)] << (s + b)) |
               (set_pool[$urandom_range(0, 2)] << b) |
               (64'($urandom) & ((64'd1 << b) - 64'd1));
      push_access(kind, addr);
      if (kind != KIND_IFETCH) data_items++;
    end
  endtask

  task automatic run_phase(logic [5:0] set_val, logic [5:0] ways_val, logic [5:0] off_val,
                           int n);
    wait_drained();
    write_regs(set_val, ways_val, off_val);
    queue_random_accesses(n);
  endtask

  initial begin
    int t;
    set_bits_reg = SET_BITS_RST;
    ways_reg = WAYS_RST;
    offset_reg = OFFSET_BITS_RST;
    for (t = 0; t < NUM_LINES; t++) begin
      line_valid[t] = 1'b0;
      line_tag[t] = '0;
      line_rank[t] = 3'd0;
    end
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: one way per set, so a new tag in a used set evicts.
    push_access(KIND_LOAD, 64'h0);
    push_access(KIND_STORE, 64'h8);
    push_access(KIND_MODIFY, 64'h0);
    push_access(KIND_IFETCH, 64'h100);
    push_access(KIND_LOAD, '1);
    push_access(KIND_STORE, '1);
    push_access(KIND_LOAD, 64'h1_0000_0000);
    push_access(KIND_LOAD, 64'h0);
    push_access(KIND_MODIFY, 64'h7FFF_FFFF_FFFF_FFF0);
    push_access(KIND_IFETCH, '1);
    wait_drained();

    // Out-of-range values clamp to eight sets bits, eight ways and a 32-bit offset.
    write_regs(6'h3F, 6'h3F, 6'h3F);
    for (t = 0; t < 9; t++) push_access(KIND_LOAD, 64'(t) << 40);
    push_access(KIND_LOAD, 64'(1) << 40);
    push_access(KIND_STORE, 64'h0);
    push_access(KIND_MODIFY, 64'(2) << 40);

    run_phase(6'd0, 6'd0, 6'd0, 110);
    run_phase(6'd15, 6'd15, 6'd63, 110);
    @(negedge clk);
    hold_seq++;
    run_phase(6'd8, 6'd8, 6'd1, 110);
    run_phase(6'd1, 6'd8, 6'd32, 110);
    run_phase(6'd2, 6'd4, 6'd6, 110);
    run_phase(6'd3, 6'd2, 6'd5, 110);
    run_phase(6'd8, 6'd3, 6'd12, 110);
    run_phase(6'd5, 6'd8, 6'd3, 110);
    wait_drained();
    quiet = 1'b1;
    run_phase(6'd1, 6'd5, 6'd2, 110);
    run_phase(6'($urandom), 6'($urandom), 6'($urandom), 110);
    wait_drained();
    repeat (10) @(negedge clk);

    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
